// File: rtl/pfk_pkg.sv
// Shared types, constants and arithmetic helpers for the arm forward kinematics datapath.
// Used by every module of the block except pfk_delay; depends on nothing.
package pfk_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int WQ = 30;
	localparam int TAB_LEN = 24;
	localparam int SQ_STEPS = 31;

	localparam int LEN_W = 20;
	localparam int LIN_W = 21;
	localparam int ANG_W = 19;
	localparam int POS_W = 23;
	localparam int ROLL_W = 19;
	localparam int PITCH_W = 18;

	typedef logic signed [31:0] trig_t;
	typedef logic signed [33:0] cw_t;
	typedef logic signed [36:0] va_t;
	typedef logic signed [35:0] ang_t;
	typedef logic signed [37:0] ow_t;
	typedef logic signed [24:0] lin_t;
	typedef logic [63:0] sq_t;

	localparam logic signed [47:0] PI_W = 48'sd3373259426;
	localparam logic signed [47:0] HALF_PI_W = 48'sd1686629713;
	localparam cw_t GAIN_W = 34'sd652032874;
	localparam sq_t SQ_FULL = 64'd1 << (2 * WQ);

	localparam ow_t POS_MAX = 38'sd2097152;
	localparam ow_t ROLL_MAX = 38'sd205887;
	localparam ow_t PITCH_MAX = 38'sd102944;

	localparam logic [1:0] OC_REGULAR = 2'd0;
	localparam logic [1:0] OC_PITCH_NEG = 2'd1;
	localparam logic [1:0] OC_PITCH_POS = 2'd2;

	typedef struct packed {
		logic [1:0] ocase;
		lin_t px;
		lin_t py;
		lin_t pz;
	} pose_t;

	typedef struct packed {
		cw_t roll_y;
		cw_t roll_x;
		cw_t pitch_y;
		cw_t yaw_y;
		cw_t yaw_x;
	} atan_in_t;

	function automatic ang_t atan_tab(input int i);
		ang_t t;
		case (i)
			0: t = 36'sd843314857;
			1: t = 36'sd497837829;
			2: t = 36'sd263043837;
			3: t = 36'sd133525159;
			4: t = 36'sd67021687;
			5: t = 36'sd33543516;
			6: t = 36'sd16775851;
			7: t = 36'sd8388437;
			8: t = 36'sd4194283;
			9: t = 36'sd2097149;
			10: t = 36'sd1048576;
			11: t = 36'sd524288;
			12: t = 36'sd262144;
			13: t = 36'sd131072;
			14: t = 36'sd65536;
			15: t = 36'sd32768;
			16: t = 36'sd16384;
			17: t = 36'sd8192;
			18: t = 36'sd4096;
			19: t = 36'sd2048;
			20: t = 36'sd1024;
			21: t = 36'sd512;
			22: t = 36'sd256;
			23: t = 36'sd128;
			default: t = '0;
		endcase
		return t;
	endfunction

	function automatic cw_t mulw(input trig_t a, input trig_t b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		return 34'((p + 64'sd536870912) >>> WQ);
	endfunction

	function automatic cw_t scale_len(input logic [LEN_W-1:0] len, input trig_t v);
		logic signed [63:0] p;
		p = 64'($signed({1'b0, len})) * 64'(v);
		return 34'((p + 64'sd536870912) >>> WQ);
	endfunction

	function automatic ow_t to_out(input ow_t v, input int frac);
		return (v + (38'sd1 <<< (WQ - frac - 1))) >>> (WQ - frac);
	endfunction

	function automatic ow_t sat_sym(input ow_t v, input ow_t lim);
		ow_t r;
		if (v > lim)
			r = lim;
		else if (v < -lim)
			r = -lim;
		else
			r = v;
		return r;
	endfunction

	function automatic int pfk_latency(input int steps);
		return 1 + (steps + 2) + 4 + (SQ_STEPS + 1) + (steps + 2) + 1;
	endfunction

endpackage

// File: rtl/pfk_delay.sv
// Fixed-depth register delay line for side data that travels next to a pipelined unit.
// Depends on nothing.
module pfk_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input logic clk,
	input logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] tap_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		tap_q[0] <= d;
	end

	for (genvar k = 1; k < DEPTH; k++) begin : g_tap
		always_ff @(posedge clk) begin
			tap_q[k] <= tap_q[k-1];
		end
	end

	assign q = tap_q[DEPTH-1];

endmodule

// File: rtl/pfk_sincos.sv
// Pipelined rotation-mode CORDIC: cosine and sine of a Q(FRAC_BITS) angle in Q2.30.
// Depends on pfk_pkg.
module pfk_sincos #(
	parameter int FRAC_BITS = pfk_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = pfk_pkg::CORDIC_STEPS_DEF
) (
	input logic clk,
	input logic signed [pfk_pkg::ANG_W-1:0] ang,
	output pfk_pkg::trig_t cos_o,
	output pfk_pkg::trig_t sin_o
);
	import pfk_pkg::*;

	logic signed [47:0] z_in;
	logic signed [47:0] z_sat;
	cw_t z_fold;
	logic neg_fold;

	cw_t x_st [0:CORDIC_STEPS];
	cw_t y_st [0:CORDIC_STEPS];
	cw_t z_st [0:CORDIC_STEPS];
	logic neg_st [0:CORDIC_STEPS];

	always_comb begin
		z_in = 48'(ang) <<< (WQ - FRAC_BITS);
		if (z_in > PI_W)
			z_sat = PI_W;
		else if (z_in < -PI_W)
			z_sat = -PI_W;
		else
			z_sat = z_in;
		neg_fold = 1'b0;
		z_fold = 34'(z_sat);
		if (z_sat > HALF_PI_W) begin
			z_fold = 34'(z_sat - PI_W);
			neg_fold = 1'b1;
		end else if (z_sat < -HALF_PI_W) begin
			z_fold = 34'(z_sat + PI_W);
			neg_fold = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		x_st[0] <= GAIN_W;
		y_st[0] <= '0;
		z_st[0] <= z_fold;
		neg_st[0] <= neg_fold;
	end

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
		always_ff @(posedge clk) begin
			if (z_st[k] >= 0) begin
				x_st[k+1] <= x_st[k] - (y_st[k] >>> k);
				y_st[k+1] <= y_st[k] + (x_st[k] >>> k);
				z_st[k+1] <= z_st[k] - 34'(atan_tab(k));
			end else begin
				x_st[k+1] <= x_st[k] + (y_st[k] >>> k);
				y_st[k+1] <= y_st[k] - (x_st[k] >>> k);
				z_st[k+1] <= z_st[k] + 34'(atan_tab(k));
			end
			neg_st[k+1] <= neg_st[k];
		end
	end

	always_ff @(posedge clk) begin
		cos_o <= 32'(neg_st[CORDIC_STEPS] ? -x_st[CORDIC_STEPS] : x_st[CORDIC_STEPS]);
		sin_o <= 32'(neg_st[CORDIC_STEPS] ? -y_st[CORDIC_STEPS] : y_st[CORDIC_STEPS]);
	end

endmodule

// File: rtl/pfk_isqrt.sv
// Pipelined floor integer square root, one result bit per stage.
// Depends on pfk_pkg.
module pfk_isqrt (
	input logic clk,
	input pfk_pkg::sq_t n_i,
	output logic [30:0] r_o
);
	import pfk_pkg::*;

	sq_t n_st [0:SQ_STEPS];
	sq_t r_st [0:SQ_STEPS];

	always_ff @(posedge clk) begin
		n_st[0] <= n_i;
		r_st[0] <= '0;
	end

	for (genvar j = 0; j < SQ_STEPS; j++) begin : g_step
		localparam sq_t BIT = 64'd1 << (2 * WQ - 2 * j);
		always_ff @(posedge clk) begin
			if (n_st[j] >= r_st[j] + BIT) begin
				n_st[j+1] <= n_st[j] - (r_st[j] + BIT);
				r_st[j+1] <= (r_st[j] >> 1) + BIT;
			end else begin
				n_st[j+1] <= n_st[j];
				r_st[j+1] <= r_st[j] >> 1;
			end
		end
	end

	assign r_o = 31'(r_st[SQ_STEPS]);

endmodule

// File: rtl/pfk_atan2.sv
// Pipelined vectoring-mode CORDIC: atan2(y, x) in Q2.30 radians, zero for a zero vector.
// Depends on pfk_pkg.
module pfk_atan2 #(
	parameter int CORDIC_STEPS = pfk_pkg::CORDIC_STEPS_DEF
) (
	input logic clk,
	input pfk_pkg::cw_t y_i,
	input pfk_pkg::cw_t x_i,
	output pfk_pkg::ang_t z_o
);
	import pfk_pkg::*;

	va_t x_pre;
	va_t y_pre;
	ang_t z_pre;

	va_t x_st [0:CORDIC_STEPS];
	va_t y_st [0:CORDIC_STEPS];
	ang_t z_st [0:CORDIC_STEPS];
	logic zero_st [0:CORDIC_STEPS];

	always_comb begin
		x_pre = 37'(x_i);
		y_pre = 37'(y_i);
		z_pre = '0;
		if (x_i < 0) begin
			z_pre = (y_i >= 0) ? 36'(PI_W) : 36'(-PI_W);
			x_pre = -37'(x_i);
			y_pre = -37'(y_i);
		end
	end

	always_ff @(posedge clk) begin
		x_st[0] <= x_pre;
		y_st[0] <= y_pre;
		z_st[0] <= z_pre;
		zero_st[0] <= (x_i == 0) && (y_i == 0);
	end

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
		always_ff @(posedge clk) begin
			if (y_st[k] >= 0) begin
				x_st[k+1] <= x_st[k] + (y_st[k] >>> k);
				y_st[k+1] <= y_st[k] - (x_st[k] >>> k);
				z_st[k+1] <= z_st[k] + atan_tab(k);
			end else begin
				x_st[k+1] <= x_st[k] - (y_st[k] >>> k);
				y_st[k+1] <= y_st[k] + (x_st[k] >>> k);
				z_st[k+1] <= z_st[k] - atan_tab(k);
			end
			zero_st[k+1] <= zero_st[k];
		end
	end

	always_ff @(posedge clk) begin
		z_o <= zero_st[CORDIC_STEPS] ? '0 : z_st[CORDIC_STEPS];
	end

endmodule

// File: rtl/pppr_arm_forward_kinematics.sv
// Forward kinematics of a three-prismatic, three-revolute arm: position and roll/pitch/yaw.
// The result passes through the two CORDIC pipelines in series and the 31-step square root
// between them. Throughput is one transaction per cycle; busy stays low.
// The receiver cannot stall: done pulses for one cycle with each result.
// Reset clears the valid chain and loads tool_offset with 655; datapath registers are not reset.
// Depends on pfk_pkg, pfk_delay, pfk_sincos, pfk_isqrt and pfk_atan2.
module pppr_arm_forward_kinematics #(
	parameter int FRAC_BITS = pfk_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = pfk_pkg::CORDIC_STEPS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic tool_offset_we,
	input logic [pfk_pkg::LEN_W-1:0] tool_offset_wdata,
	input logic signed [pfk_pkg::LIN_W-1:0] prismatic_1,
	input logic signed [pfk_pkg::LIN_W-1:0] prismatic_2,
	input logic signed [pfk_pkg::LIN_W-1:0] prismatic_3,
	input logic signed [pfk_pkg::ANG_W-1:0] revolute_4,
	input logic signed [pfk_pkg::ANG_W-1:0] revolute_5,
	input logic signed [pfk_pkg::ANG_W-1:0] revolute_6,
	output logic done,
	output logic signed [pfk_pkg::POS_W-1:0] pos_x,
	output logic signed [pfk_pkg::POS_W-1:0] pos_y,
	output logic signed [pfk_pkg::POS_W-1:0] pos_z,
	output logic signed [pfk_pkg::ROLL_W-1:0] roll,
	output logic signed [pfk_pkg::PITCH_W-1:0] pitch,
	output logic signed [pfk_pkg::ROLL_W-1:0] yaw,
	output logic [1:0] orientation_case
);
	import pfk_pkg::*;

	localparam int LATENCY = pfk_latency(CORDIC_STEPS);
	localparam int ROT_LAT = CORDIC_STEPS + 2;
	localparam int SQ_LAT = SQ_STEPS + 1;
	localparam int AT_LAT = CORDIC_STEPS + 2;
	localparam ow_t ONE_F = 38'sd1 <<< FRAC_BITS;

	logic [LEN_W-1:0] tool_offset_q;
	logic [LATENCY-1:0] vld_q;

	logic signed [LIN_W-1:0] q1_s1, q2_s1, q3_s1;
	logic signed [ANG_W-1:0] a4_s1, a5_s1, a6_s1;
	logic signed [LIN_W-1:0] q1_d, q2_d, q3_d;

	trig_t c4, s4, c5, s5, c6, s6;

	cw_t c4s5_s2, s4s5_s2, c5s6_s2, c5c6_s2;
	trig_t c4_s2, s4_s2, c5_s2, c6_s2, s6_s2;
	lin_t q1_s2, q2_s2, q3_s2;

	cw_t m0_s3, m1_s3, m2_s3, m3_s3, m4_s3, m5_s3, m6_s3, m7_s3;
	cw_t slx_s3, sly_s3, slz_s3, r02_s3, s4s5_s3, nc5_s3;
	lin_t q1_s3, q2_s3, q3_s3;
	ow_t r02f;

	cw_t r00_s4, r01_s4, r10_s4, r11_s4, r02_s4, s4s5_s4, nc5_s4;
	lin_t px_s4, py_s4, pz_s4;
	logic [1:0] case_s4;
	sq_t sq_s4;

	sq_t rest_s5;
	pose_t pose_s5;
	atan_in_t ain_s5;

	pose_t pose_d;
	atan_in_t ain_d;
	logic [30:0] root;
	ang_t z_roll, z_pitch, z_yaw;

	ow_t roll_w, pitch_w, yaw_w;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tool_offset_q <= LEN_W'(655);
			vld_q <= '0;
		end else begin
			if (tool_offset_we)
				tool_offset_q <= tool_offset_wdata;
			vld_q <= {vld_q[LATENCY-2:0], start & ~busy};
		end
	end

	assign done = vld_q[LATENCY-1];

	always_ff @(posedge clk) begin
		q1_s1 <= prismatic_1;
		q2_s1 <= prismatic_2;
		q3_s1 <= prismatic_3;
		a4_s1 <= revolute_4;
		a5_s1 <= revolute_5;
		a6_s1 <= revolute_6;
	end

	pfk_sincos #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_sc4 (
		.clk(clk), .ang(a4_s1), .cos_o(c4), .sin_o(s4));
	pfk_sincos #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_sc5 (
		.clk(clk), .ang(a5_s1), .cos_o(c5), .sin_o(s5));
	pfk_sincos #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_sc6 (
		.clk(clk), .ang(a6_s1), .cos_o(c6), .sin_o(s6));

	pfk_delay #(.WIDTH(3 * LIN_W), .DEPTH(ROT_LAT)) u_lin_dly (
		.clk(clk), .d({q1_s1, q2_s1, q3_s1}), .q({q1_d, q2_d, q3_d}));

	always_ff @(posedge clk) begin
		c4s5_s2 <= mulw(c4, s5);
		s4s5_s2 <= mulw(s4, s5);
		c5s6_s2 <= mulw(c5, s6);
		c5c6_s2 <= mulw(c5, c6);
		c4_s2 <= c4;
		s4_s2 <= s4;
		c5_s2 <= c5;
		c6_s2 <= c6;
		s6_s2 <= s6;
		q1_s2 <= 25'(q1_d);
		q2_s2 <= 25'(q2_d);
		q3_s2 <= 25'(q3_d);
	end

	always_ff @(posedge clk) begin
		m0_s3 <= mulw(c4_s2, 32'(c5s6_s2));
		m1_s3 <= mulw(s4_s2, c6_s2);
		m2_s3 <= mulw(c4_s2, 32'(c5c6_s2));
		m3_s3 <= mulw(s4_s2, s6_s2);
		m4_s3 <= mulw(s4_s2, 32'(c5s6_s2));
		m5_s3 <= mulw(c4_s2, c6_s2);
		m6_s3 <= mulw(s4_s2, 32'(c5c6_s2));
		m7_s3 <= mulw(c4_s2, s6_s2);
		slx_s3 <= scale_len(tool_offset_q, 32'(c4s5_s2));
		sly_s3 <= scale_len(tool_offset_q, 32'(s4s5_s2));
		slz_s3 <= scale_len(tool_offset_q, c5_s2);
		r02_s3 <= -c4s5_s2;
		s4s5_s3 <= s4s5_s2;
		nc5_s3 <= -34'(c5_s2);
		q1_s3 <= q1_s2;
		q2_s3 <= q2_s2;
		q3_s3 <= q3_s2;
	end

	assign r02f = to_out(38'(r02_s3), FRAC_BITS);

	always_ff @(posedge clk) begin
		r00_s4 <= m0_s3 - m1_s3;
		r01_s4 <= m2_s3 + m3_s3;
		r10_s4 <= m4_s3 + m5_s3;
		r11_s4 <= m6_s3 - m7_s3;
		r02_s4 <= r02_s3;
		s4s5_s4 <= s4s5_s3;
		nc5_s4 <= nc5_s3;
		px_s4 <= q1_s3 - 25'(slx_s3);
		py_s4 <= q2_s3 - 25'(sly_s3);
		pz_s4 <= q3_s3 - 25'(slz_s3);
		sq_s4 <= 64'(66'(r02_s3) * 66'(r02_s3));
		if (r02f >= ONE_F)
			case_s4 <= OC_PITCH_POS;
		else if (r02f <= -ONE_F)
			case_s4 <= OC_PITCH_NEG;
		else
			case_s4 <= OC_REGULAR;
	end

	always_ff @(posedge clk) begin
		rest_s5 <= (sq_s4 < SQ_FULL) ? SQ_FULL - sq_s4 : '0;
		pose_s5.ocase <= case_s4;
		pose_s5.px <= px_s4;
		pose_s5.py <= py_s4;
		pose_s5.pz <= pz_s4;
		ain_s5.roll_y <= (case_s4 == OC_REGULAR) ? s4s5_s4 : r10_s4;
		ain_s5.roll_x <= (case_s4 == OC_REGULAR) ? nc5_s4 : r11_s4;
		ain_s5.pitch_y <= r02_s4;
		ain_s5.yaw_y <= -r01_s4;
		ain_s5.yaw_x <= r00_s4;
	end

	pfk_isqrt u_sqrt (.clk(clk), .n_i(rest_s5), .r_o(root));

	pfk_delay #(.WIDTH($bits(atan_in_t)), .DEPTH(SQ_LAT)) u_ain_dly (
		.clk(clk), .d(ain_s5), .q(ain_d));

	pfk_delay #(.WIDTH($bits(pose_t)), .DEPTH(SQ_LAT + AT_LAT)) u_pose_dly (
		.clk(clk), .d(pose_s5), .q(pose_d));

	pfk_atan2 #(.CORDIC_STEPS(CORDIC_STEPS)) u_at_roll (
		.clk(clk), .y_i(ain_d.roll_y), .x_i(ain_d.roll_x), .z_o(z_roll));
	pfk_atan2 #(.CORDIC_STEPS(CORDIC_STEPS)) u_at_pitch (
		.clk(clk), .y_i(ain_d.pitch_y), .x_i(34'($signed({1'b0, root}))), .z_o(z_pitch));
	pfk_atan2 #(.CORDIC_STEPS(CORDIC_STEPS)) u_at_yaw (
		.clk(clk), .y_i(ain_d.yaw_y), .x_i(ain_d.yaw_x), .z_o(z_yaw));

	always_comb begin
		roll_w = to_out(38'(z_roll), FRAC_BITS);
		pitch_w = to_out(38'(z_pitch), FRAC_BITS);
		yaw_w = to_out(38'(z_yaw), FRAC_BITS);
		case (pose_d.ocase)
			OC_PITCH_POS: begin
				pitch_w = to_out(38'(HALF_PI_W), FRAC_BITS);
				yaw_w = '0;
			end
			OC_PITCH_NEG: begin
				roll_w = -roll_w;
				pitch_w = to_out(38'(-HALF_PI_W), FRAC_BITS);
				yaw_w = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		pos_x <= POS_W'(sat_sym(38'(pose_d.px), POS_MAX));
		pos_y <= POS_W'(sat_sym(38'(pose_d.py), POS_MAX));
		pos_z <= POS_W'(sat_sym(38'(pose_d.pz), POS_MAX));
		roll <= ROLL_W'(sat_sym(roll_w, ROLL_MAX));
		pitch <= PITCH_W'(sat_sym(pitch_w, PITCH_MAX));
		yaw <= ROLL_W'(sat_sym(yaw_w, ROLL_MAX));
		orientation_case <= pose_d.ocase;
	end

endmodule

// File: rtl/pfk_checker.sv
// Port-level checks on the kinematics block's transaction timing and orientation cases.
// Depends on pfk_pkg; bound to pppr_arm_forward_kinematics at the end of this file.
module pfk_port_checks #(
	parameter int CORDIC_STEPS = pfk_pkg::CORDIC_STEPS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic signed [pfk_pkg::PITCH_W-1:0] pitch,
	input logic signed [pfk_pkg::ROLL_W-1:0] yaw,
	input logic [1:0] orientation_case
);
	import pfk_pkg::*;

	localparam int LATENCY = pfk_latency(CORDIC_STEPS);

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted transaction produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##LATENCY !done)
		else $error("result without an accepted transaction");

	a_yaw_singular: assert property (@(posedge clk) disable iff (!arst_n)
		(done && orientation_case != OC_REGULAR) |-> (yaw == 0))
		else $error("nonzero yaw in a singular pose");

	a_pitch_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(done && orientation_case == OC_PITCH_POS) |-> (pitch > 0))
		else $error("pitch not positive in the plus 90 degree case");

	a_pitch_neg: assert property (@(posedge clk) disable iff (!arst_n)
		(done && orientation_case == OC_PITCH_NEG) |-> (pitch < 0))
		else $error("pitch not negative in the minus 90 degree case");

endmodule

bind pppr_arm_forward_kinematics pfk_port_checks #(.CORDIC_STEPS(CORDIC_STEPS)) u_pfk_checker (.*);

// File: dv/pfk_checker.sv
// Checker for pppr_arm_forward_kinematics: watches the input, configuration and result
// channels, predicts each pose and compares it with the block's output.
// Depends on pfk_pkg for port widths and orientation codes.
module pfk_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic tool_offset_we,
	input logic [pfk_pkg::LEN_W-1:0] tool_offset_wdata,
	input logic signed [pfk_pkg::LIN_W-1:0] prismatic_1,
	input logic signed [pfk_pkg::LIN_W-1:0] prismatic_2,
	input logic signed [pfk_pkg::LIN_W-1:0] prismatic_3,
	input logic signed [pfk_pkg::ANG_W-1:0] revolute_4,
	input logic signed [pfk_pkg::ANG_W-1:0] revolute_5,
	input logic signed [pfk_pkg::ANG_W-1:0] revolute_6,
	input logic done,
	input logic signed [pfk_pkg::POS_W-1:0] pos_x,
	input logic signed [pfk_pkg::POS_W-1:0] pos_y,
	input logic signed [pfk_pkg::POS_W-1:0] pos_z,
	input logic signed [pfk_pkg::ROLL_W-1:0] roll,
	input logic signed [pfk_pkg::PITCH_W-1:0] pitch,
	input logic signed [pfk_pkg::ROLL_W-1:0] yaw,
	input logic [1:0] orientation_case,
	output int fail_count,
	output int pending
);
	import pfk_pkg::*;

	localparam longint PI_Q = 64'sd3373259426;
	localparam longint HALF_PI_Q = 64'sd1686629713;
	localparam longint GAIN_Q = 64'sd652032874;
	localparam longint ONE_Q = 64'sd1 <<< 30;
	localparam int STEPS = 16;

	typedef struct packed {
		logic signed [POS_W-1:0] px;
		logic signed [POS_W-1:0] py;
		logic signed [POS_W-1:0] pz;
		logic signed [ROLL_W-1:0] rl;
		logic signed [PITCH_W-1:0] pt;
		logic signed [ROLL_W-1:0] yw;
		logic [1:0] oc;
	} pose_res_t;

	pose_res_t expected_poses[$];
	logic [LEN_W-1:0] tool_len;
	int mismatches;

	function automatic longint clampl(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint qmul(longint a, longint b);
		return (a * b + (ONE_Q >>> 1)) >>> 30;
	endfunction

	function automatic longint narrow(longint v);
		return (v + (64'sd1 <<< 13)) >>> 14;
	endfunction

	function automatic longint atan_entry(int i);
		longint t[16] = '{843314857, 497837829, 263043837, 133525159, 67021687,
			33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288,
			262144, 131072, 65536, 32768};
		return t[i];
	endfunction

	function automatic void rotate_unit(input longint angle, output longint c,
			output longint s);
		longint x, y, z, dx, dy;
		logic flip;
		x = GAIN_Q;
		y = 0;
		flip = 1'b0;
		z = clampl(angle, -PI_Q, PI_Q);
		if (z > HALF_PI_Q) begin
			z -= PI_Q;
			flip = 1'b1;
		end else if (z < -HALF_PI_Q) begin
			z += PI_Q;
			flip = 1'b1;
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = x >>> i;
			dy = y >>> i;
			if (z >= 0) begin
				x -= dy;
				y += dx;
				z -= atan_entry(i);
			end else begin
				x += dy;
				y -= dx;
				z += atan_entry(i);
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic longint vector_angle(longint y, longint x);
		longint z, dx, dy;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			z = (y >= 0) ? PI_Q : -PI_Q;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = x >>> i;
			dy = y >>> i;
			if (y >= 0) begin
				x += dy;
				y -= dx;
				z += atan_entry(i);
			end else begin
				x -= dy;
				y += dx;
				z -= atan_entry(i);
			end
		end
		return z;
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic pose_res_t predict_pose(longint q1, longint q2, longint q3,
			longint a4, longint a5, longint a6, longint len);
		longint c4, s4, c5, s5, c6, s6;
		longint c4s5, s4s5, c5s6, c5c6, r00, r01, r02, r10, r11, r02n;
		longint px, py, pz, rl, pt, yw;
		longint unsigned sq, rest;
		pose_res_t r;
		rotate_unit(a4 <<< 14, c4, s4);
		rotate_unit(a5 <<< 14, c5, s5);
		rotate_unit(a6 <<< 14, c6, s6);
		c4s5 = qmul(c4, s5);
		s4s5 = qmul(s4, s5);
		c5s6 = qmul(c5, s6);
		c5c6 = qmul(c5, c6);
		px = q1 - qmul(len, c4s5);
		py = q2 - qmul(len, s4s5);
		pz = q3 - qmul(len, c5);
		r00 = qmul(c4, c5s6) - qmul(s4, c6);
		r01 = qmul(c4, c5c6) + qmul(s4, s6);
		r02 = -c4s5;
		r10 = qmul(s4, c5s6) + qmul(c4, c6);
		r11 = qmul(s4, c5c6) - qmul(c4, s6);
		r02n = narrow(r02);
		if (r02n >= 65536) begin
			r.oc = OC_PITCH_POS;
			rl = narrow(vector_angle(r10, r11));
			pt = narrow(HALF_PI_Q);
			yw = 0;
		end else if (r02n <= -65536) begin
			r.oc = OC_PITCH_NEG;
			rl = -narrow(vector_angle(r10, r11));
			pt = narrow(-HALF_PI_Q);
			yw = 0;
		end else begin
			sq = longint'(r02 * r02);
			rest = (sq < (64'd1 << 60)) ? (64'd1 << 60) - sq : 0;
			r.oc = OC_REGULAR;
			rl = narrow(vector_angle(s4s5, -c5));
			pt = narrow(vector_angle(r02, longint'(floor_sqrt(rest))));
			yw = narrow(vector_angle(-r01, r00));
		end
		r.px = POS_W'(clampl(px, -2097152, 2097152));
		r.py = POS_W'(clampl(py, -2097152, 2097152));
		r.pz = POS_W'(clampl(pz, -2097152, 2097152));
		r.rl = ROLL_W'(clampl(rl, -205887, 205887));
		r.pt = PITCH_W'(clampl(pt, -102944, 102944));
		r.yw = ROLL_W'(clampl(yw, -205887, 205887));
		return r;
	endfunction

	assign fail_count = mismatches;
	assign pending = expected_poses.size();

	always @(posedge clk or negedge arst_n) begin
		pose_res_t got, want;
		if (!arst_n) begin
			tool_len = 20'd655;
			expected_poses.delete();
			mismatches = 0;
		end else begin
			if (done) begin
				got = '{pos_x, pos_y, pos_z, roll, pitch, yaw, orientation_case};
				if (expected_poses.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: result with no transaction outstanding");
				end else begin
					want = expected_poses.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("ERROR: pose mismatch exp x=%0d y=%0d z=%0d ",
								want.px, want.py, want.pz,
								"r=%0d p=%0d w=%0d c=%0d ",
								want.rl, want.pt, want.yw, want.oc,
								"got x=%0d y=%0d z=%0d ",
								got.px, got.py, got.pz,
								"r=%0d p=%0d w=%0d c=%0d",
								got.rl, got.pt, got.yw, got.oc);
					end
				end
			end
			if (start && !busy)
				expected_poses.insert(expected_poses.size(),
					predict_pose(prismatic_1, prismatic_2, prismatic_3,
					revolute_4, revolute_5, revolute_6, longint'(tool_len)));
			if (tool_offset_we)
				tool_len = tool_offset_wdata;
		end
	end
endmodule

// File: dv/pppr_arm_forward_kinematics_tb.sv
// Testbench top for pppr_arm_forward_kinematics: drives directed and random joint sets
// across several tool offsets, with random gaps, and reports the verdict.
// Depends on pfk_pkg, the block and pfk_checker.
module pppr_arm_forward_kinematics_tb;
	import pfk_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic tool_offset_we = 1'b0;
	logic [LEN_W-1:0] tool_offset_wdata = '0;
	logic signed [LIN_W-1:0] prismatic_1 = '0, prismatic_2 = '0, prismatic_3 = '0;
	logic signed [ANG_W-1:0] revolute_4 = '0, revolute_5 = '0, revolute_6 = '0;
	logic done;
	logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
	logic signed [ROLL_W-1:0] roll, yaw;
	logic signed [PITCH_W-1:0] pitch;
	logic [1:0] orientation_case;
	int fail_count, pending;
	logic no_gaps;

	always #10 clk = ~clk;

	pppr_arm_forward_kinematics dut (.*);
	pfk_checker u_checker (.*);

	task automatic send_joints(input int q1, q2, q3, a4, a5, a6);
		@(negedge clk);
		start = 1'b1;
		prismatic_1 = LIN_W'(q1);
		prismatic_2 = LIN_W'(q2);
		prismatic_3 = LIN_W'(q3);
		revolute_4 = ANG_W'(a4);
		revolute_5 = ANG_W'(a5);
		revolute_6 = ANG_W'(a6);
		while (busy)
			@(negedge clk);
	endtask

	task automatic idle_gap();
		int n, k;
		k = $urandom_range(0, 99);
		n = (no_gaps || k < 60) ? 0 : (k < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40));
		repeat (n) begin
			@(negedge clk);
			start = 1'b0;
		end
	endtask

	task automatic drain_and_set_tool(input logic [LEN_W-1:0] len);
		@(negedge clk);
		start = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
		tool_offset_we = 1'b1;
		tool_offset_wdata = len;
		@(negedge clk);
		tool_offset_we = 1'b0;
	endtask

	function automatic int rand_lin();
		int k;
		k = $urandom_range(0, 9);
		if (k < 7)
			return $urandom_range(0, 1048576) - 524288;
		return $signed(21'($urandom));
	endfunction

	function automatic int rand_ang(input int k);
		if (k < 6)
			return $urandom_range(0, 411774) - 205887;
		if (k < 8)
			return $signed(19'($urandom));
		return ($urandom_range(0, 1) ? 102944 : -102944) + $urandom_range(0, 8) - 4;
	endfunction

	task automatic random_block(input int count);
		int a4;
		repeat (count) begin
			if ($urandom_range(0, 199) == 0)
				no_gaps = ~no_gaps;
			a4 = $urandom_range(0, 3) == 0 ?
				(($urandom_range(0, 2) - 1) * 205887 + $urandom_range(0, 6) - 3) :
				rand_ang($urandom_range(0, 7));
			send_joints(rand_lin(), rand_lin(), rand_lin(), a4,
				rand_ang($urandom_range(0, 9)), rand_ang($urandom_range(0, 7)));
			idle_gap();
		end
	endtask

	initial begin
		no_gaps = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		send_joints(0, 0, 0, 0, 0, 0);
		send_joints(524288, -524288, 524288, 205887, -205887, 205887);
		send_joints(-524288, 524288, -524288, -205887, 205887, -205887);
		send_joints(-1048576, 1048575, -1048576, 262143, -262144, 0);
		send_joints(0, 0, 0, 0, 102944, 0);
		send_joints(0, 0, 0, 0, -102944, 0);
		send_joints(0, 0, 0, 205887, 102944, 51472);
		send_joints(0, 0, 0, -205887, -102944, -51472);
		send_joints(65536, 65536, 65536, 0, 102944, 205887);
		send_joints(1, -1, 0, 102944, 102944, 102944);
		send_joints(0, 0, 0, 0, 0, 262143);
		idle_gap();
		random_block(400);
		drain_and_set_tool(20'd0);
		random_block(400);
		drain_and_set_tool(20'hFFFFF);
		send_joints(-524288, -524288, -524288, 0, 102944, 0);
		send_joints(524288, 524288, 524288, 205887, -102944, 0);
		random_block(400);
		drain_and_set_tool(20'($urandom));
		random_block(400);
		drain_and_set_tool(20'd655);
		random_block(380);
		@(negedge clk);
		start = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#20000000;
		$display("Regression FAIL");
		$finish;
	end
endmodule
